// File: design/ess_pkg.sv
// Shared types, constants and the magic signature table for the signature scanner.
// No dependencies; every other design file but ess_in_if imports this package.
package ess_pkg;

  // field widths fixed by the result format
  localparam int OFFSET_BITS = 29;
  localparam int TOTAL_BITS  = OFFSET_BITS + 1;
  localparam int INDEX_BITS  = 5;

  // table shape
  localparam int TABLE_SLOTS  = 32;
  localparam int MASK_BITS    = 18;
  localparam int MAX_SIG_LEN  = 15;
  localparam int LEN_BITS     = 5;
  localparam int SIG_PAT_BITS = 8 * MAX_SIG_LEN;

  // defaults for the top-level parameters
  localparam int WINDOW_BYTES_DEF   = 15;
  localparam int NUM_SIGNATURES_DEF = 18;

  // per-item result limit, the summary takes one slot on an end-of-file item
  localparam int MAX_RESULTS = 16;
  localparam int RC_BITS     = 5;
  localparam logic [RC_BITS-1:0] CAP_EOF = RC_BITS'(MAX_RESULTS - 1);

  // output queue
  localparam int FIFO_DEPTH = 2;

  // configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int REG_IDX_BITS  = 1;
  localparam logic [REG_IDX_BITS-1:0] REG_MIN_LEN = 1'b0;
  localparam logic [REG_IDX_BITS-1:0] REG_ENABLE  = 1'b1;
  localparam logic [LEN_BITS-1:0]  MIN_LEN_RST = LEN_BITS'(4);
  localparam logic [MASK_BITS-1:0] ENABLE_RST  = '1;

  // result kinds
  localparam logic KIND_HIT     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [LEN_BITS-1:0]  min_len;
    logic [MASK_BITS-1:0] en_mask;
  } cfg_t;

  typedef struct packed {
    logic                   kind;
    logic [OFFSET_BITS-1:0] offset;
    logic [INDEX_BITS-1:0]  index;
    logic [TOTAL_BITS-1:0]  total;
    logic                   exceeded;
    logic                   last;
  } res_t;

  typedef struct packed {
    logic                   hit;
    logic [INDEX_BITS-1:0]  index;
    logic [TABLE_SLOTS-1:0] vec;
  } match_t;

  // one table entry, byte 0 of the signature in the top byte of pat
  typedef struct packed {
    logic [LEN_BITS-1:0]     len;
    logic [SIG_PAT_BITS-1:0] pat;
  } sig_entry_t;

  function automatic sig_entry_t sig_entry(input int unsigned i);
    sig_entry_t e;
    e = '0;
    unique case (i)
      0:  e = '{len: 5'd8,  pat: {64'h89504E470D0A1A0A, 56'h0}};
      1:  e = '{len: 5'd3,  pat: {24'hFFD8FF, 96'h0}};
      2:  e = '{len: 5'd4,  pat: {32'h47494638, 88'h0}};
      3:  e = '{len: 5'd5,  pat: {40'h255044462D, 80'h0}};
      4:  e = '{len: 5'd4,  pat: {32'h504B0304, 88'h0}};
      5:  e = '{len: 5'd4,  pat: {32'h7F454C46, 88'h0}};
      6:  e = '{len: 5'd2,  pat: {16'h4D5A, 104'h0}};
      7:  e = '{len: 5'd3,  pat: {24'h1F8B08, 96'h0}};
      8:  e = '{len: 5'd6,  pat: {48'h526172211A07, 72'h0}};
      9:  e = '{len: 5'd6,  pat: {48'h377ABCAF271C, 72'h0}};
      10: e = '{len: 5'd2,  pat: {16'h424D, 104'h0}};
      11: e = '{len: 5'd15, pat: 120'h53514C69746520666F726D61742033};
      12: e = '{len: 5'd4,  pat: {32'h52494646, 88'h0}};
      13: e = '{len: 5'd4,  pat: {32'h4F676753, 88'h0}};
      14: e = '{len: 5'd4,  pat: {32'h664C6143, 88'h0}};
      15: e = '{len: 5'd3,  pat: {24'h494433, 96'h0}};
      16: e = '{len: 5'd4,  pat: {32'h49492A00, 88'h0}};
      17: e = '{len: 5'd4,  pat: {32'h4D4D002A, 88'h0}};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// File: design/ess_in_if.sv
// Input channel of the signature scanner: one file byte per transaction.
// Depends on nothing beyond the valid/ready handshake.
interface ess_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_file;

  modport source (output valid, output data_byte, output byte_valid, output end_of_file,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input end_of_file,
                  output ready);
endinterface

// File: design/ess_out_if.sv
// Result channel of the signature scanner: one hit or summary per transaction.
// Depends on ess_pkg for the offset, index and total widths.
interface ess_out_if;
  import ess_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   result_kind;
  logic [OFFSET_BITS-1:0] hit_offset;
  logic [INDEX_BITS-1:0]  signature_index;
  logic [TOTAL_BITS-1:0]  hit_total;
  logic                   length_exceeded;
  logic                   final_result;

  modport source (output valid, output result_kind, output hit_offset,
                  output signature_index, output hit_total, output length_exceeded,
                  output final_result, input ready);
  modport sink   (input valid, input result_kind, input hit_offset,
                  input signature_index, input hit_total, input length_exceeded,
                  input final_result, output ready);
endinterface

// File: design/ess_cfg_regs.sv
// APB-style configuration registers: minimum signature length and enable mask.
// Depends on ess_pkg for register indexes, reset values and cfg_t.
module ess_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ess_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output ess_pkg::cfg_t                      cfg
);
  import ess_pkg::*;

  cfg_t                    cfg_r;
  cfg_t                    cfg_nxt;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    wr_en;

  // register index from the word address
  assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_LEN: cfg_nxt.min_len = pwdata[LEN_BITS-1:0];
        REG_ENABLE:  cfg_nxt.en_mask = pwdata[MASK_BITS-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_len <= MIN_LEN_RST;
      cfg_r.en_mask <= ENABLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_MIN_LEN: prdata = 32'(cfg_r.min_len);
      REG_ENABLE:  prdata = 32'(cfg_r.en_mask);
      default:     prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// File: design/ess_matcher.sv
// Parallel compare of the window head against every enabled table signature.
// Depends on ess_pkg for the signature table, cfg_t and match_t.
module ess_matcher #(
  parameter int WINDOW_BYTES   = ess_pkg::WINDOW_BYTES_DEF,
  parameter int NUM_SIGNATURES = ess_pkg::NUM_SIGNATURES_DEF
) (
  input  logic [7:0]                           win [WINDOW_BYTES],
  input  logic [$clog2(WINDOW_BYTES+1)-1:0]    avail,
  input  ess_pkg::cfg_t                        cfg,
  output ess_pkg::match_t                      match
);
  import ess_pkg::*;

  localparam int CMP_LEN = (WINDOW_BYTES < MAX_SIG_LEN) ? WINDOW_BYTES : MAX_SIG_LEN;

  logic [TABLE_SLOTS-1:0] mask_ext;
  logic [TABLE_SLOTS-1:0] vec;

  assign mask_ext = TABLE_SLOTS'(cfg.en_mask);

  // one comparator per signature, all in parallel
  always_comb begin
    sig_entry_t ent;
    logic       eq;
    logic       ok;
    vec = '0;
    for (int i = 0; i < NUM_SIGNATURES; i++) begin
      ent = sig_entry(i);
      eq  = 1'b1;
      for (int k = 0; k < CMP_LEN; k++) begin
        if ((k < int'(ent.len)) && (win[k] != ent.pat[SIG_PAT_BITS-1-8*k -: 8])) begin
          eq = 1'b0;
        end
      end
      ok = (ent.len != '0) && (ent.len >= cfg.min_len) && mask_ext[i] &&
           (int'(ent.len) <= int'(avail)) && (int'(ent.len) <= WINDOW_BYTES);
      vec[i] = ok && eq;
    end
  end

  // lowest table index wins
  always_comb begin
    match.vec   = vec;
    match.hit   = |vec;
    match.index = '0;
    for (int i = NUM_SIGNATURES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        match.index = INDEX_BITS'(i);
      end
    end
  end

endmodule

// File: design/ess_out_fifo.sv
// Two-entry result queue that decouples the scan engine from a stalling receiver.
// Depends on ess_pkg for res_t and the queue depth.
module ess_out_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ess_pkg::res_t push_data,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output ess_pkg::res_t out_data
);
  import ess_pkg::*;

  localparam int PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

  res_t                slot_r [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wptr_r;
  logic [PTR_BITS-1:0] wptr_nxt;
  logic [PTR_BITS-1:0] rptr_r;
  logic [PTR_BITS-1:0] rptr_nxt;
  logic [CNT_BITS-1:0] cnt_r;
  logic [CNT_BITS-1:0] cnt_nxt;
  logic                pop;

  assign space     = cnt_r < CNT_BITS'(FIFO_DEPTH);
  assign out_valid = cnt_r != '0;
  assign out_data  = slot_r[rptr_r];
  assign pop       = out_valid && out_ready;

  // pointer and occupancy update
  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

// File: design/embedded_signature_scanner.sv
// Top level of the embedded signature scanner: input register, window, scan engine.
// Depends on ess_pkg, ess_in_if, ess_out_if, ess_cfg_regs, ess_matcher and ess_out_fifo.
//
// Usage: a file is streamed in one byte per in_ch transaction (byte_valid marks a real
// byte, end_of_file marks the last transaction of the file). Each start offset is
// checked against the enabled magic signatures once the following bytes are known,
// and a hit gives one out_ch transaction with its offset and table index. The
// end-of-file transaction drains the window and then gives a summary with the hit
// total and the size-limit flag; final_result marks the last result of an input.
// Timing: out_ch.valid rises in the cycle after the engine step that decides a result.
// Throughput: bytes may arrive every cycle while the result queue has space; an
// end-of-file transaction first takes its byte, then decides one window position per
// cycle through the single comparator bank (again only while the queue has space),
// then gives the summary.
// Reset (synchronous, rst_n low) empties the window and clears the offset, hit count
// and overflow flag; the registers return to minimum length 4 and all signatures on.
// Configuration is written over the cfg_ APB port by the user only while the scanner is
// idle; the block does not enforce this. When the receiver stalls, results wait in a
// two-entry queue; once it is full the engine pauses and in_ch.ready drops until a result is taken.
module embedded_signature_scanner #(
  parameter int WINDOW_BYTES   = ess_pkg::WINDOW_BYTES_DEF,
  parameter int NUM_SIGNATURES = ess_pkg::NUM_SIGNATURES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ess_in_if.sink                            in_ch,
  ess_out_if.source                         out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ess_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import ess_pkg::*;

  localparam int FB       = $clog2(WINDOW_BYTES + 1);
  localparam int IDX_BITS = $clog2(WINDOW_BYTES);
  localparam logic [OFFSET_BITS+1:0] SIZE_LIMIT = (OFFSET_BITS + 2)'(1) << OFFSET_BITS;
  localparam logic [TOTAL_BITS-1:0]  TOTAL_MAX  = '1;

  typedef enum logic [1:0] {
    ST_BYTE  = 2'b01,
    ST_FLUSH = 2'b10
  } engine_state_t;

  // input register
  logic       item_v_r;
  logic       item_v_nxt;
  logic [7:0] item_byte_r;
  logic       item_bv_r;
  logic       item_eof_r;
  logic       accept;

  // scan state
  engine_state_t            state_r;
  engine_state_t            state_nxt;
  logic [7:0]               win_r   [WINDOW_BYTES];
  logic [7:0]               win_nxt [WINDOW_BYTES];
  logic [FB-1:0]            fill_r;
  logic [FB-1:0]            fill_nxt;
  logic [OFFSET_BITS:0]     oldest_r;
  logic [OFFSET_BITS:0]     oldest_nxt;
  logic [TOTAL_BITS-1:0]    hits_r;
  logic [TOTAL_BITS-1:0]    hits_nxt;
  logic [TOTAL_BITS-1:0]    hits_inc;
  logic                     ovf_r;
  logic                     ovf_nxt;
  logic [RC_BITS-1:0]       rc_r;
  logic [RC_BITS-1:0]       rc_nxt;
  logic [OFFSET_BITS+1:0]   where_w;
  logic                     fill_full;

  // engine controls
  cfg_t   cfg;
  match_t m;
  res_t   hit_res;
  res_t   sum_res;
  res_t   push_data;
  res_t   head;
  logic   push;
  logic   space;
  logic   go;
  logic   done;
  logic   do_shift;
  logic   do_write;

  // configuration registers
  ess_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // comparator bank on the window head
  ess_matcher #(
    .WINDOW_BYTES   (WINDOW_BYTES),
    .NUM_SIGNATURES (NUM_SIGNATURES)
  ) u_match (
    .win   (win_r),
    .avail (fill_r),
    .cfg   (cfg),
    .match (m)
  );

  // input handshake, the register frees up in the cycle its item completes
  assign in_ch.ready = !item_v_r || done;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    item_v_nxt = item_v_r;
    if (accept) begin
      item_v_nxt = 1'b1;
    end else if (done) begin
      item_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_byte_r <= in_ch.data_byte;
      item_bv_r   <= in_ch.byte_valid;
      item_eof_r  <= in_ch.end_of_file;
    end
  end

  // helpers
  assign go        = item_v_r && space;
  assign where_w   = {1'b0, oldest_r} + (OFFSET_BITS + 2)'(fill_r);
  assign fill_full = fill_r == FB'(WINDOW_BYTES);
  assign hits_inc  = (hits_r == TOTAL_MAX) ? hits_r : hits_r + 1'b1;

  always_comb begin
    hit_res          = '0;
    hit_res.kind     = KIND_HIT;
    hit_res.offset   = oldest_r[OFFSET_BITS-1:0];
    hit_res.index    = m.index;
    sum_res          = '0;
    sum_res.kind     = KIND_SUMMARY;
    sum_res.total    = hits_r;
    sum_res.exceeded = ovf_r;
    sum_res.last     = 1'b1;
  end

  // scan engine: at most one window position decided per cycle, while the result queue has space
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    hits_nxt   = hits_r;
    ovf_nxt    = ovf_r;
    rc_nxt     = rc_r;
    push       = 1'b0;
    push_data  = hit_res;
    done       = 1'b0;
    do_shift   = 1'b0;
    do_write   = 1'b0;
    if (go) begin
      unique case (state_r)
        ST_BYTE: begin
          rc_nxt = '0;
          if (item_bv_r) begin
            if (where_w >= SIZE_LIMIT) begin
              ovf_nxt = 1'b1;
            end else if (fill_full) begin
              // oldest position is decided and leaves, the new byte enters
              do_shift   = 1'b1;
              oldest_nxt = oldest_r + 1'b1;
              if (m.hit) begin
                hits_nxt       = hits_inc;
                push           = 1'b1;
                push_data.last = !item_eof_r;
                rc_nxt         = RC_BITS'(1);
              end
            end else begin
              do_write = 1'b1;
              fill_nxt = fill_r + 1'b1;
            end
          end
          if (item_eof_r) begin
            state_nxt = ST_FLUSH;
          end else begin
            done = 1'b1;
          end
        end
        ST_FLUSH: begin
          if (fill_r != '0) begin
            do_shift   = 1'b1;
            fill_nxt   = fill_r - 1'b1;
            oldest_nxt = oldest_r + 1'b1;
            if (m.hit) begin
              hits_nxt = hits_inc;
              // hits past the cap are counted but not reported
              if (rc_r < CAP_EOF) begin
                push   = 1'b1;
                rc_nxt = rc_r + 1'b1;
              end
            end
          end else begin
            // window drained: summary, then back to a fresh file
            push       = 1'b1;
            push_data  = sum_res;
            oldest_nxt = '0;
            hits_nxt   = '0;
            ovf_nxt    = 1'b0;
            state_nxt  = ST_BYTE;
            done       = 1'b1;
          end
        end
        default: begin
          state_nxt = ST_BYTE;
        end
      endcase
    end
  end

  // window shift line
  always_comb begin
    for (int k = 0; k < WINDOW_BYTES; k++) begin
      win_nxt[k] = win_r[k];
    end
    if (do_shift) begin
      for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
        win_nxt[k] = win_r[k + 1];
      end
      win_nxt[WINDOW_BYTES-1] = item_byte_r;
    end else if (do_write) begin
      for (int k = 0; k < WINDOW_BYTES; k++) begin
        if (IDX_BITS'(k) == fill_r[IDX_BITS-1:0]) begin
          win_nxt[k] = item_byte_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < WINDOW_BYTES; k++) begin
      win_r[k] <= win_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_BYTE;
      fill_r   <= '0;
      oldest_r <= '0;
      hits_r   <= '0;
      ovf_r    <= 1'b0;
      rc_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      oldest_r <= oldest_nxt;
      hits_r   <= hits_nxt;
      ovf_r    <= ovf_nxt;
      rc_r     <= rc_nxt;
    end
  end

  // result queue
  ess_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (head)
  );

  assign out_ch.result_kind     = head.kind;
  assign out_ch.hit_offset      = head.offset;
  assign out_ch.signature_index = head.index;
  assign out_ch.hit_total       = head.total;
  assign out_ch.length_exceeded = head.exceeded;
  assign out_ch.final_result    = head.last;

  // window never holds more than its size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FB'(WINDOW_BYTES))
    else $error("window fill beyond its size");

  // the table has distinct prefixes, so one position matches at most one signature
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(m.vec))
    else $error("more than one signature matched at one position");

  // a summary leaves the per-file state cleared
  a_summary_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_data.kind == KIND_SUMMARY) |=> (fill_r == '0 && hits_r == '0 && !ovf_r))
    else $error("file state not cleared after summary");

  // no byte past the size limit is ever held
  a_size_limit: assert property (@(posedge clk) disable iff (!rst_n)
    where_w <= SIZE_LIMIT)
    else $error("window holds a byte beyond the size limit");

endmodule
